/* rtl/cocktail_shaker_sorter_core_assert.svh */
// assertion macros for the cocktail shaker sorter
`ifndef COCKTAIL_SHAKER_SORTER_CORE_ASSERT_SVH
`define COCKTAIL_SHAKER_SORTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cocktail shaker sorter check failed");

`define CSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("cocktail shaker sorter check failed");

`else

`define CSS_ASSERT(label, prop)

`define CSS_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/css_pkg.sv */
// package for the cocktail shaker sorter: widths, states and compare function
package css_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned DefCapacity = 64;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [9:0] {
    S_LOAD      = 10'b00_0000_0001,
    S_ROUND     = 10'b00_0000_0010,
    S_FWD_FIRST = 10'b00_0000_0100,
    S_FWD       = 10'b00_0000_1000,
    S_FWD_END   = 10'b00_0001_0000,
    S_BWD       = 10'b00_0010_0000,
    S_BWD_END   = 10'b00_0100_0000,
    S_EMIT_RD   = 10'b00_1000_0000,
    S_EMIT_LD   = 10'b01_0000_0000,
    S_EMIT_OUT  = 10'b10_0000_0000
  } css_state_e;

  function automatic logic out_of_order(input logic descending, input data_t left,
                                        input data_t right);
    logic res;
    res = descending ? (left < right) : (left > right);
    return res;
  endfunction

endpackage

/* rtl/cocktail_shaker_sorter_core.sv */
// cocktail shaker sorter: loads a set into a memory, sorts it in place, streams it out
// each shaker round over bounds lo..hi makes a forward and then a backward pass; the
// single read port feeds one compare-swap per cycle through a carried element;
// at most CAPACITY/2 rounds, fewer when a round makes no swap
// each result beat passes S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT; S_EMIT_OUT holds while stalled
// reset clears control state and the order bit; the element memory is not cleared
`include "cocktail_shaker_sorter_core_assert.svh"

module cocktail_shaker_sorter_core #(
  parameter int unsigned CAPACITY = css_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,    // sort_descending
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic signed [css_pkg::DataW-1:0]  s_axis_tdata,   // value [31:0]
  input  logic                              s_axis_tlast,   // last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic signed [css_pkg::DataW-1:0]  m_axis_tdata,   // sorted_value [31:0]
  output logic                              m_axis_tlast,   // final_res
  output logic                              m_axis_tuser    // overflow
);

  import css_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  data_t                mem_q [CAPACITY];
  data_t                rdata_q;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [AddrW-1:0]     mem_raddr;
  data_t                mem_wdata;

  css_state_e           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AddrW-1:0]     lo_q, lo_d;
  logic [AddrW-1:0]     hi_q, hi_d;
  logic [AddrW-1:0]     idx_q, idx_d;
  data_t                carry_q, carry_d;
  logic                 swap_q, swap_d;
  logic                 drop_q, drop_d;
  logic                 desc_q;
  logic                 out_valid_q, out_valid_d;
  data_t                out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;
  logic                 out_user_q, out_user_d;

  logic                 in_acc;
  logic                 out_acc;
  logic                 ooo;
  logic [AddrW-1:0]     idx_inc;
  logic [AddrW-1:0]     idx_dec;
  logic [AddrW-1:0]     lo_next;
  logic [AddrW-1:0]     hi_next;
  logic [CntW-1:0]      cnt_dec;

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  assign idx_inc = idx_q + AddrW'(1);
  assign idx_dec = idx_q - AddrW'(1);
  assign lo_next = lo_q + AddrW'(1);
  assign hi_next = hi_q - AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    carry_d     = carry_q;
    swap_d      = swap_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = carry_q;
    mem_raddr   = idx_q;
    ooo         = 1'b0;
    cnt_dec     = '0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CntW'(CAPACITY)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[AddrW-1:0];
            mem_wdata = s_axis_tdata;
            cnt_d     = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            cnt_dec = cnt_d - CntW'(1);
            lo_d    = '0;
            hi_d    = cnt_dec[AddrW-1:0];
            idx_d   = '0;
            if (cnt_dec == '0) begin
              state_d = S_EMIT_RD;
            end else begin
              state_d = S_ROUND;
            end
          end
        end
      end
      S_ROUND: begin
        mem_raddr = lo_q;
        idx_d     = lo_q;
        swap_d    = 1'b0;
        state_d   = S_FWD_FIRST;
      end
      S_FWD_FIRST: begin
        carry_d   = rdata_q;
        mem_raddr = idx_inc;
        state_d   = S_FWD;
      end
      S_FWD: begin
        ooo       = out_of_order(desc_q, carry_q, rdata_q);
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = ooo ? rdata_q : carry_q;
        carry_d   = ooo ? carry_q : rdata_q;
        swap_d    = swap_q | ooo;
        if (idx_inc == hi_q) begin
          state_d = S_FWD_END;
        end else begin
          mem_raddr = idx_inc + AddrW'(1);
          idx_d     = idx_inc;
        end
      end
      S_FWD_END: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = carry_q;
        mem_raddr = hi_next;
        idx_d     = hi_q;
        state_d   = S_BWD;
      end
      S_BWD: begin
        ooo       = out_of_order(desc_q, rdata_q, carry_q);
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = ooo ? rdata_q : carry_q;
        carry_d   = ooo ? carry_q : rdata_q;
        swap_d    = swap_q | ooo;
        if (idx_dec == lo_q) begin
          state_d = S_BWD_END;
        end else begin
          mem_raddr = idx_dec - AddrW'(1);
          idx_d     = idx_dec;
        end
      end
      S_BWD_END: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = carry_q;
        lo_d      = lo_next;
        hi_d      = hi_next;
        if (swap_q && (hi_next > lo_next)) begin
          state_d = S_ROUND;
        end else begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        mem_raddr = idx_q;
        state_d   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cnt_dec     = cnt_q - CntW'(1);
        out_valid_d = 1'b1;
        out_data_d  = rdata_q;
        out_last_d  = (CntW'(idx_q) == cnt_dec);
        out_user_d  = drop_q;
        state_d     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_inc;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      idx_q       <= '0;
      swap_q      <= 1'b0;
      drop_q      <= 1'b0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      idx_q       <= idx_d;
      swap_q      <= swap_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

  `CSS_ASSERT(a_cnt_in_range, cnt_q <= CntW'(CAPACITY))
  `CSS_ASSERT(a_bounds_ordered, (state_q == S_FWD || state_q == S_BWD) |-> lo_q < hi_q)
  `CSS_ASSERT(a_fwd_idx_below_hi, (state_q == S_FWD) |-> idx_q < hi_q)
  `CSS_ASSERT(a_final_returns_to_load, (out_acc && out_last_q) |=> (state_q == S_LOAD && cnt_q == '0))
  `CSS_ASSERT(a_valid_only_emitting, out_valid_q |-> state_q == S_EMIT_OUT)

endmodule
